// ===== src/record_table_score_statistics_defines.svh =====
// Assertion macros shared by the record table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef RECORD_TABLE_SCORE_STATISTICS_DEFINES_SVH
`define RECORD_TABLE_SCORE_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RTSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RTSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/rtss_pkg.sv =====
// Shared types and constants for the record table with score statistics.
// No dependencies.
package rtss_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int SCORE_W      = 10;
    localparam int ID_W         = 32;
    localparam int REC_W        = ID_W + 2 * SCORE_W;

    localparam int STATUS_W = 3;
    localparam int ECOUNT_W = 8;
    localparam int SUM_W    = 17;
    localparam int MEAN_W   = 14;
    localparam int MEDIAN_W = 11;
    localparam int RANGE_W  = 10;
    localparam int VAR_W    = 22;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_EDIT   = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DUP    = 3'd1,
        ST_NEG    = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADIDX = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

endpackage

// ===== src/rtss_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rtss_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module rtss_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_div;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            ge;

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/record_table_score_statistics.sv =====
// Record table with score statistics: top level, sequencer and datapath.
// Depends on rtss_pkg, rtss_ram, rtss_div and the shared assertion macros.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | cmd, slot_index, id_number, scores
//  out     | output    | o_out_valid / i_out_ready  | status, count, sum, mean, median ...
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | subject_select
//
// Edit completes straight from idle; add runs a duplicate scan over the table RAM;
// delete moves the later entries down, one entry per cycle through the RAM port.
// Report: ten selection passes over the table (one median bit per pass), then the
// multiplier steps and two divisions (mean, then variance).
// Reset clears control only; the table needs no clearing pass.
// One command at a time: o_in_ready drops until the result word is taken.
`include "record_table_score_statistics_defines.svh"

module record_table_score_statistics
    import rtss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [6:0]          i_slot_index,
    input  logic [ID_W-1:0]     i_id_number,
    input  logic signed [10:0]  i_score_first,
    input  logic signed [10:0]  i_score_second,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ECOUNT_W-1:0] o_entry_count,
    output logic [SUM_W-1:0]    o_score_sum,
    output logic [MEAN_W-1:0]   o_score_mean,
    output logic [MEDIAN_W-1:0] o_score_median,
    output logic [RANGE_W-1:0]  o_score_range,
    output logic [VAR_W-1:0]    o_score_variance,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_subject_select
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SUMW = CW + SCORE_W;
    localparam int SQW  = CW + 2 * SCORE_W;
    localparam int PW   = 2 * SQW;
    localparam int NW   = CW + SQW;
    localparam int DW   = NW + 4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DUP   = 6'b000010,
        S_SHIFT = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MUL   = 6'b010000,
        S_DIV   = 6'b100000
    } t_state;

    localparam logic [SCORE_W-1:0] BIT_TOP = {1'b1, {(SCORE_W-1){1'b0}}};

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_sel;
    logic [ID_W-1:0]     r_id, n_id;
    logic [SCORE_W-1:0]  r_s1, n_s1, r_s2, n_s2;
    logic                r_neg, n_neg;
    logic                r_dup, n_dup;
    logic [CW-1:0]       r_rd_addr, n_rd_addr;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    logic                r_dv, n_dv, r_pv, n_pv;
    logic [SUMW-1:0]     r_sum, n_sum;
    logic [SQW-1:0]      r_sumsq, n_sumsq;
    logic [SCORE_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic [SCORE_W-1:0]  r_mask, n_mask, r_bsel, n_bsel;
    logic [SCORE_W-1:0]  r_pa, n_pa, r_pb, n_pb;
    logic [CW-1:0]       r_ka, n_ka, r_kb, n_kb, r_ca, n_ca, r_cb, n_cb;
    logic [PW-1:0]       r_prod;
    logic [1:0]          r_mstep, n_mstep;
    logic [NW-1:0]       r_sq, n_sq, r_nsq, n_nsq;
    logic [2*CW-1:0]     r_nn, n_nn;
    logic                r_dstep, n_dstep, r_dgo, n_dgo;
    logic [MEAN_W-1:0]   r_mean, n_mean;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ECOUNT_W-1:0] r_ecount;
    logic [SUM_W-1:0]    r_osum;
    logic [MEAN_W-1:0]   r_omean;
    logic [MEDIAN_W-1:0] r_omed;
    logic [RANGE_W-1:0]  r_orng;
    logic [VAR_W-1:0]    r_ovar;

    logic                in_acc, in_neg, bad_idx, issue, walk_done, first;
    logic [REC_W-1:0]    ram_rdata, ram_wdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ID_W-1:0]     rd_id;
    logic [SCORE_W-1:0]  v;
    logic                match_a, match_b;
    logic [SQW-1:0]      mul_a, mul_b;
    logic [PW-1:0]       mul_p;
    logic                div_done;
    logic [DW-1:0]       div_q, div_dividend, div_divisor;
    logic [NW-1:0]       num;

    logic                res_go;
    t_status             res_status;
    logic [SUM_W-1:0]    res_sum;
    logic [MEAN_W-1:0]   res_mean;
    logic [MEDIAN_W-1:0] res_med;
    logic [RANGE_W-1:0]  res_rng;
    logic [VAR_W-1:0]    res_var;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc  = i_in_valid && o_in_ready;
    assign in_neg  = i_score_first[SCORE_W] || i_score_second[SCORE_W];
    assign bad_idx = ((CW + 7)'(i_slot_index) >= (CW + 7)'(r_count));
    assign issue     = (r_rd_addr < r_count);
    assign walk_done = !issue && !r_dv && !r_pv;
    assign first     = r_bsel[SCORE_W-1];

    assign rd_id = ram_rdata[REC_W-1 -: ID_W];
    assign v = r_sel ? ram_rdata[SCORE_W-1:0] : ram_rdata[2*SCORE_W-1 -: SCORE_W];
    // Bit-serial selection: match the decided prefix and a zero at the current bit.
    assign match_a = (((v ^ r_pa) & r_mask) == '0) && ((v & r_bsel) == '0);
    assign match_b = (((v ^ r_pb) & r_mask) == '0) && ((v & r_bsel) == '0);

    always_comb begin
        case (r_state)
            S_SCAN: begin
                mul_a = SQW'(v);
                mul_b = SQW'(v);
            end
            default: begin
                case (r_mstep)
                    2'd0: begin
                        mul_a = SQW'(r_sum);
                        mul_b = SQW'(r_sum);
                    end
                    2'd1: begin
                        mul_a = SQW'(r_count);
                        mul_b = r_sumsq;
                    end
                    default: begin
                        mul_a = SQW'(r_count);
                        mul_b = SQW'(r_count);
                    end
                endcase
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign num   = r_nsq - r_sq;
    assign div_dividend = r_dstep ? {num, 4'b0000} : DW'({r_sum, 4'b0000});
    assign div_divisor  = r_dstep ? DW'(r_nn) : DW'(r_count);

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_id = r_id;
        n_s1 = r_s1;         n_s2 = r_s2;         n_neg = r_neg;
        n_dup = r_dup;       n_rd_addr = r_rd_addr; n_wr_addr = r_wr_addr;
        n_dv = r_dv;         n_pv = r_pv;         n_sum = r_sum;
        n_sumsq = r_sumsq;   n_lo = r_lo;         n_hi = r_hi;
        n_mask = r_mask;     n_bsel = r_bsel;     n_pa = r_pa;
        n_pb = r_pb;         n_ka = r_ka;         n_kb = r_kb;
        n_ca = r_ca;         n_cb = r_cb;         n_mstep = r_mstep;
        n_sq = r_sq;         n_nsq = r_nsq;       n_nn = r_nn;
        n_dstep = r_dstep;   n_dgo = r_dgo;       n_mean = r_mean;
        ram_we = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {r_id, r_s1, r_s2};
        res_go = 1'b0;       res_status = ST_OK;
        res_sum = '0;        res_mean = '0;       res_med = '0;
        res_rng = '0;        res_var = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            n_id = i_id_number;
                            n_s1 = i_score_first[SCORE_W-1:0];
                            n_s2 = i_score_second[SCORE_W-1:0];
                            n_neg = in_neg;
                            n_dup = 1'b0;
                            n_rd_addr = '0;
                            n_state = S_DUP;
                        end
                        CMD_DEL: begin
                            if (bad_idx) begin
                                res_go = 1'b1;
                                res_status = ST_BADIDX;
                            end else begin
                                n_rd_addr = CW'(i_slot_index) + 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_EDIT: begin
                            res_go = 1'b1;
                            if (bad_idx) begin
                                res_status = ST_BADIDX;
                            end else if (in_neg) begin
                                res_status = ST_NEG;
                            end else begin
                                ram_we = 1'b1;
                                ram_waddr = AW'(i_slot_index);
                                ram_wdata = {i_id_number, i_score_first[SCORE_W-1:0],
                                             i_score_second[SCORE_W-1:0]};
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                res_go = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                n_sum = '0;  n_sumsq = '0;
                                n_lo = '1;   n_hi = '0;
                                n_mask = '0; n_bsel = BIT_TOP;
                                n_pa = '0;   n_pb = '0;
                                n_ka = (r_count - 1'b1) >> 1;
                                n_kb = r_count >> 1;
                                n_ca = '0;   n_cb = '0;
                                n_rd_addr = '0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DUP: begin
                n_dv = issue;
                if (issue) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                end
                if (r_dv && (rd_id == r_id)) begin
                    n_dup = 1'b1;
                end
                if (walk_done) begin
                    res_go = 1'b1;
                    n_state = S_IDLE;
                    if (r_dup) begin
                        res_status = ST_DUP;
                    end else if (r_neg) begin
                        res_status = ST_NEG;
                    end else if (r_count >= CW'(CAPACITY)) begin
                        res_status = ST_FULL;
                    end else begin
                        ram_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                // read entry i+1, write it to i in the next cycle
                n_dv = issue;
                if (issue) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_wr_addr = AW'(r_rd_addr - 1'b1);
                end
                if (r_dv) begin
                    ram_we = 1'b1;
                    ram_waddr = r_wr_addr;
                    ram_wdata = ram_rdata;
                end
                if (walk_done) begin
                    n_count = r_count - 1'b1;
                    res_go = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                n_dv = issue;
                n_pv = r_dv && first;
                if (issue) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                end
                if (r_dv) begin
                    if (first) begin
                        n_sum = r_sum + SUMW'(v);
                        if (v < r_lo) n_lo = v;
                        if (v > r_hi) n_hi = v;
                    end
                    if (match_a) n_ca = r_ca + 1'b1;
                    if (match_b) n_cb = r_cb + 1'b1;
                end
                if (r_pv) begin
                    n_sumsq = r_sumsq + r_prod[SQW-1:0];
                end
                if (walk_done) begin
                    if (r_ka >= r_ca) begin
                        n_pa = r_pa | r_bsel;
                        n_ka = r_ka - r_ca;
                    end
                    if (r_kb >= r_cb) begin
                        n_pb = r_pb | r_bsel;
                        n_kb = r_kb - r_cb;
                    end
                    n_ca = '0;
                    n_cb = '0;
                    if (r_bsel[0]) begin
                        n_mstep = 2'd0;
                        n_state = S_MUL;
                    end else begin
                        n_mask = (r_mask >> 1) | BIT_TOP;
                        n_bsel = r_bsel >> 1;
                        n_rd_addr = '0;
                    end
                end
            end
            S_MUL: begin
                // product is taken the cycle after its operands are set
                n_pv = !r_pv;
                if (r_pv) begin
                    n_mstep = r_mstep + 1'b1;
                    case (r_mstep)
                        2'd0: n_sq = r_prod[NW-1:0];
                        2'd1: n_nsq = r_prod[NW-1:0];
                        default: begin
                            n_nn = r_prod[2*CW-1:0];
                            n_pv = 1'b0;
                            n_dstep = 1'b0;
                            n_dgo = 1'b1;
                            n_state = S_DIV;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_dgo = 1'b0;
                if (div_done) begin
                    if (!r_dstep) begin
                        n_mean = div_q[MEAN_W-1:0];
                        n_dstep = 1'b1;
                        n_dgo = 1'b1;
                    end else begin
                        res_go = 1'b1;
                        res_sum = SUM_W'(r_sum);
                        res_mean = r_mean;
                        res_med = {1'b0, r_pa} + {1'b0, r_pb};
                        res_rng = RANGE_W'(r_hi - r_lo);
                        res_var = div_q[VAR_W-1:0];
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sel       <= 1'b0;
            r_dv        <= 1'b0;
            r_pv        <= 1'b0;
            r_dgo       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_pv    <= n_pv;
            r_dgo   <= n_dgo;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sel <= i_cfg_subject_select;
            end
            if (res_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;         r_s1 <= n_s1;         r_s2 <= n_s2;
        r_neg <= n_neg;       r_dup <= n_dup;       r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr; r_sum <= n_sum;     r_sumsq <= n_sumsq;
        r_lo <= n_lo;         r_hi <= n_hi;         r_mask <= n_mask;
        r_bsel <= n_bsel;     r_pa <= n_pa;         r_pb <= n_pb;
        r_ka <= n_ka;         r_kb <= n_kb;         r_ca <= n_ca;
        r_cb <= n_cb;         r_mstep <= n_mstep;   r_sq <= n_sq;
        r_nsq <= n_nsq;       r_nn <= n_nn;         r_dstep <= n_dstep;
        r_mean <= n_mean;     r_prod <= mul_p;
        if (res_go) begin
            r_status <= res_status;
            r_ecount <= ECOUNT_W'(n_count);
            r_osum   <= res_sum;
            r_omean  <= res_mean;
            r_omed   <= res_med;
            r_orng   <= res_rng;
            r_ovar   <= res_var;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_entry_count    = r_ecount;
    assign o_score_sum      = r_osum;
    assign o_score_mean     = r_omean;
    assign o_score_median   = r_omed;
    assign o_score_range    = r_orng;
    assign o_score_variance = r_ovar;

    rtss_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    rtss_div #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    `RTSS_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `RTSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    `RTSS_ASSERT_IMPL(a_count_step, i_clk, i_rst_n, r_count != $past(r_count), (r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count)))
    `RTSS_ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !r_dv && !r_pv)

endmodule
